>>> design/depth_linearize_colorize_macros.svh
// Assertion macros shared by the depth colouriser checker.
// No dependencies; included by the checker file.
`ifndef DEPTH_LINEARIZE_COLORIZE_MACROS_SVH
`define DEPTH_LINEARIZE_COLORIZE_MACROS_SVH

// same-cycle implication, reset-qualified
`define DLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define DLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dlc_pkg.sv
// Shared constants for the depth linearise / colourise block.
// No dependencies.
package dlc_pkg;
	localparam int DEPTH_RAW_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd3;

	localparam logic [15:0] NEAR_RST   = 16'd100;
	localparam logic [15:0] FAR_RST    = 16'd20000;
	localparam logic [11:0] OFFSET_RST = 12'd1090;
	localparam logic [23:0] SCALE_RST  = 24'd348000;

	localparam logic [15:0] DEPTH_SAT  = 16'hFFFF;
	localparam logic [13:0] GAMMA_GAIN = 14'd9216;

	// colour ramp selected by gamma[13:8]
	localparam logic [5:0] BAND_WHITE_RED   = 6'd0;
	localparam logic [5:0] BAND_RED_YELLOW  = 6'd1;
	localparam logic [5:0] BAND_YELLOW_GRN  = 6'd2;
	localparam logic [5:0] BAND_GRN_CYAN    = 6'd3;
	localparam logic [5:0] BAND_CYAN_BLUE   = 6'd4;
	localparam logic [5:0] BAND_BLUE_BLACK  = 6'd5;
endpackage

>>> design/dlc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No package dependencies.
module dlc_div_pipe #(
	parameter int NW = 56,
	parameter int DW = 41,
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [DW-1:0] den_o,
	output logic          ovf,
	output logic [SW-1:0] side_o
);
	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [CW-1:0] rem_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic          ovf_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// quotient too big for QW bits (also catches a zero divisor)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= CW'(num);
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			side_s[0] <= side;
			ovf_s[0]  <= CW'(num) >= (CW'(den) << QW);
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		localparam int B = QW - j;
		logic [CW-1:0] trial;
		logic          take;

		assign trial = CW'(den_s[j-1]) << B;
		assign take  = rem_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? rem_s[j-1] - trial : rem_s[j-1];
				quo_s[j]  <= quo_s[j-1] | (take ? (QW'(1) << B) : QW'(0));
				den_s[j]  <= den_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_vld = vld_s[QW];
	assign quo     = quo_s[QW];
	assign rem     = DW'(rem_s[QW]);
	assign den_o   = den_s[QW];
	assign ovf     = ovf_s[QW];
	assign side_o  = side_s[QW];
endmodule

>>> design/depth_linearize_colorize.sv
// Depth-buffer linearise and colourise, top level.
// Uses dlc_pkg and dlc_div_pipe.
//
// Takes one fractional depth sample per transaction and returns linear depth in mm
// (rounded half up, saturated at 65535) plus an RGB colour from the emulated disparity
// and its cubic gamma curve. Fully pipelined: one transaction per clock in and out while the
// output is not stalled. The pipe holds two input stages, the depth
// divider (18 stages: overflow check plus 17 quotient bits), rounding, the disparity
// divider (13 stages: overflow check plus 12 quotient bits), the clamp, three multiply
// stages for 9216*k^3 and the output register. GAMMA_ENTRIES must be a power of two;
// the gamma scaling by GAMMA_ENTRIES^3 is then a plain bit select. A stall on the
// output freezes the whole pipe; in_ready is high whenever the output register is empty
// or being drained. Registers are written through cfg_we/cfg_idx/cfg_wdata; write
// them only with the pipe empty.
module depth_linearize_colorize
	import dlc_pkg::*;
#(
	parameter int GAMMA_ENTRIES   = 2048,
	parameter int DEPTH_FRAC_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [DEPTH_RAW_W-1:0] depth_raw,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            depth_mm,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	localparam int F    = DEPTH_FRAC_BITS;
	localparam int PW   = DEPTH_RAW_W + 17;               // signed product width
	localparam int DENW = ((16 + F > PW) ? 16 + F : PW) + 2;
	localparam int DW   = DENW - 1;                        // divisor magnitude
	localparam int NW   = 32 + F;
	localparam int KW   = $clog2(GAMMA_ENTRIES);
	localparam int GNW  = 3 * KW + 14;

	// config registers
	logic [15:0] near_q, far_q;
	logic [11:0] offset_q;
	logic [23:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q   <= NEAR_RST;
			far_q    <= FAR_RST;
			offset_q <= OFFSET_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NEAR:   near_q   <= cfg_wdata[15:0];
				REG_FAR:    far_q    <= cfg_wdata[15:0];
				REG_OFFSET: offset_q <= cfg_wdata[11:0];
				REG_SCALE:  scale_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipe advances together; output stage is the last register
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// s1: d * (far - near)
	logic signed [16:0]   span;
	logic signed [PW-1:0] prod_s1;
	logic                 v_s1;

	assign span = 17'(far_q) - 17'(near_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) prod_s1 <= $signed({17'b0, depth_raw}) * $signed({{24{span[16]}}, span});
	end

	// s2: divisor = far<<F - product, non-positive means saturate
	logic signed [DENW-1:0] den_c, den_s2;
	logic                   bad_s2, v_s2;
	logic [NW-1:0]          num_c;

	assign den_c = ($signed(DENW'(far_q)) <<< F)
		- $signed({{(DENW-PW){prod_s1[PW-1]}}, prod_s1});
	assign num_c = NW'(32'(near_q) * 32'(far_q)) << F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= den_c;
			bad_s2 <= den_c <= 0;
		end
	end

	// depth division
	logic          dv_vld, dv_ovf, dv_bad;
	logic [16:0]   dv_quo;
	logic [DW-1:0] dv_rem, dv_den;

	dlc_div_pipe #(.NW(NW), .DW(DW), .QW(17), .SW(1)) u_depth_div (
		.clk, .arst_n, .en,
		.in_vld(v_s2), .num(num_c), .den(DW'(den_s2)), .side(bad_s2),
		.out_vld(dv_vld), .quo(dv_quo), .rem(dv_rem), .den_o(dv_den),
		.ovf(dv_ovf), .side_o(dv_bad)
	);

	// s3: round half up and saturate
	logic        rnd_up;
	logic [17:0] qr;
	logic [15:0] z_s3;
	logic        v_s3;

	assign rnd_up = {dv_rem, 1'b0} >= {1'b0, dv_den};
	assign qr     = 18'(dv_quo) + 18'(rnd_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dv_vld;
	end
	always_ff @(posedge clk) begin
		if (en) z_s3 <= (dv_bad || dv_ovf || qr > 18'(DEPTH_SAT)) ? DEPTH_SAT : qr[15:0];
	end

	// disparity quotient ceil(scale/z), 12 bits plus overflow
	logic        zz;
	logic [24:0] cnum;
	logic        cv_vld, cv_ovf;
	logic [11:0] cv_quo;
	logic [15:0] cv_rem, cv_den;
	logic [16:0] cv_side;

	assign zz   = z_s3 == 16'd0;
	assign cnum = zz ? 25'd0 : 25'(scale_q) + 25'(z_s3) - 25'd1;

	dlc_div_pipe #(.NW(25), .DW(16), .QW(12), .SW(17)) u_disp_div (
		.clk, .arst_n, .en,
		.in_vld(v_s3), .num(cnum), .den(z_s3), .side({z_s3, zz}),
		.out_vld(cv_vld), .quo(cv_quo), .rem(cv_rem), .den_o(cv_den),
		.ovf(cv_ovf), .side_o(cv_side)
	);

	// s4: k = offset - c clamped to the table range
	logic [11:0]   kdiff;
	logic [KW-1:0] k_c, k_s4;
	logic [15:0]   z_s4;
	logic          v_s4;

	assign kdiff = offset_q - cv_quo;

	always_comb begin
		if (cv_side[0] || cv_ovf || cv_quo >= offset_q || (cv_rem != cv_rem) ||
		    (cv_den == 16'd0))
			k_c = '0;
		else if (13'(kdiff) > 13'(GAMMA_ENTRIES - 1))
			k_c = KW'(GAMMA_ENTRIES - 1);
		else
			k_c = KW'(kdiff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= cv_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_s4 <= k_c;
			z_s4 <= cv_side[16:1];
		end
	end

	// s5..s7: 9216 * k^3, one multiply per stage
	logic [KW-1:0]   k_s5;
	logic [2*KW-1:0] k2_s5;
	logic [3*KW-1:0] k3_s6;
	logic [GNW-1:0]  n_s7;
	logic [15:0]     z_s5, z_s6, z_s7;
	logic            v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k2_s5 <= (2*KW)'(k_s4) * (2*KW)'(k_s4);
			k_s5  <= k_s4;
			z_s5  <= z_s4;
			k3_s6 <= (3*KW)'(k2_s5) * (3*KW)'(k_s5);
			z_s6  <= z_s5;
			n_s7  <= GNW'(k3_s6) * GNW'(GAMMA_GAIN);
			z_s7  <= z_s6;
		end
	end

	// gamma = n / entries^3, entries a power of two: top 14 bits
	logic [13:0] gam;
	assign gam = n_s7[3*KW +: 14];

	// s8: colour ramp, output register
	logic [7:0] lb, r_c, g_c, b_c;
	assign lb = gam[7:0];

	always_comb begin
		unique case (gam[13:8])
			BAND_WHITE_RED:  begin r_c = 8'd255;     g_c = 8'd255 - lb; b_c = 8'd255 - lb; end
			BAND_RED_YELLOW: begin r_c = 8'd255;     g_c = lb;          b_c = 8'd0;        end
			BAND_YELLOW_GRN: begin r_c = 8'd255 - lb; g_c = 8'd255;     b_c = 8'd0;        end
			BAND_GRN_CYAN:   begin r_c = 8'd0;       g_c = 8'd255;      b_c = lb;          end
			BAND_CYAN_BLUE:  begin r_c = 8'd0;       g_c = 8'd255 - lb; b_c = 8'd255;      end
			BAND_BLUE_BLACK: begin r_c = 8'd0;       g_c = 8'd0;        b_c = 8'd255 - lb; end
			default:         begin r_c = 8'd0;       g_c = 8'd0;        b_c = 8'd0;        end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			depth_mm <= z_s7;
			red      <= r_c;
			green    <= g_c;
			blue     <= b_c;
		end
	end
endmodule

>>> design/dlc_checker.sv
// Port-level checker for depth_linearize_colorize, with its bind.
// Depends on dlc_pkg and depth_linearize_colorize_macros.svh.
`include "depth_linearize_colorize_macros.svh"

module dlc_checker
	import dlc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [15:0]            depth_mm,
	input logic [7:0]             red,
	input logic [7:0]             green,
	input logic [7:0]             blue
);
	// stalled output keeps valid, depth and red
	`DLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(depth_mm) && $stable(red), "output changed while stalled")
	// empty output register never blocks the input
	`DLC_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with empty output")
	// zero depth gives zero disparity, hence white
	`DLC_ASSERT_NOW(a_zero_white, out_valid && depth_mm == 16'd0, red == 8'd255 && green == 8'd255 && blue == 8'd255, "zero depth not white")
	// every ramp pins red to a rail, except yellow-green, which pins green to full
	`DLC_ASSERT_NOW(a_red_rail, out_valid, red == 8'd255 || red == 8'd0 || green == 8'd255, "colour off ramp")
endmodule

bind depth_linearize_colorize dlc_checker u_dlc_checker (.*);
